// ===== hw/rtl/aesb_pkg.sv =====
package aesb_pkg;

    localparam int NUM_ROUNDS = 10;
    localparam int BLK_W      = 128;
    localparam int HALF_W     = 64;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = CFG_IDX_W'(1);

    localparam logic [7:0] GF_POLY = 8'h1b;
    localparam logic [7:0] RCON_1  = 8'h01;

    typedef logic [BLK_W-1:0] t_block;

    // One slot of the round pipeline: block state plus the round key it goes with
    typedef struct packed {
        logic   valid;
        t_block state;
        t_block key;
    } t_stage;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
    endfunction

    // Round constant for round r (1-based), worked out at elaboration
    function automatic logic [7:0] rcon_of(input int r);
        logic [7:0] rc;
        rc = RCON_1;
        for (int i = 1; i < r; i++) begin
            rc = xtime(rc);
        end
        return rc;
    endfunction

    // Byte 0 of the block sits in the top bits
    function automatic logic [7:0] get_byte(input t_block b, input int i);
        return b[BLK_W-1-8*i -: 8];
    endfunction

    function automatic t_block sub_shift(input t_block s);
        t_block t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[BLK_W-1-8*(4*c+r) -: 8] = SBOX[get_byte(s, 4*((c+r)%4)+r)];
            end
        end
        return t;
    endfunction

    function automatic t_block col_mix(input t_block t);
        t_block     s;
        logic [7:0] a0, a1, a2, a3, all;
        s = '0;
        for (int c = 0; c < 4; c++) begin
            a0  = get_byte(t, 4*c);
            a1  = get_byte(t, 4*c+1);
            a2  = get_byte(t, 4*c+2);
            a3  = get_byte(t, 4*c+3);
            all = a0 ^ a1 ^ a2 ^ a3;
            s[BLK_W-1-8*(4*c)   -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
            s[BLK_W-1-8*(4*c+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
            s[BLK_W-1-8*(4*c+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
            s[BLK_W-1-8*(4*c+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
        end
        return s;
    endfunction

    // One step of the key schedule: four words in, next four words out
    function automatic t_block key_expand(input t_block k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, rot, t, n0, n1, n2, n3;
        w0  = k[127:96];
        w1  = k[95:64];
        w2  = k[63:32];
        w3  = k[31:0];
        rot = {w3[23:0], w3[31:24]};
        t   = {SBOX[rot[31:24]], SBOX[rot[23:16]], SBOX[rot[15:8]], SBOX[rot[7:0]]}
              ^ {rc, 24'h000000};
        n0  = w0 ^ t;
        n1  = w1 ^ n0;
        n2  = w2 ^ n1;
        n3  = w3 ^ n2;
        return {n0, n1, n2, n3};
    endfunction

endpackage

// ===== hw/rtl/aes128_block_encrypt.sv =====
// AES-128 encryption engine, one 128-bit block per transaction, one ciphertext
// block out for each block in. The key lives in two 64-bit registers written
// through the configuration port (index 0: key bytes 0-7, index 1: key bytes
// 8-15, byte 0 in the top bits; other indexes are ignored; both reset to zero);
// write them only while the engine is empty. Data moves through a row of ten
// round cells; each cell applies one cipher round and expands the round key one
// step, so the key travels beside its block and nothing is precomputed. With no
// output stall, a block accepted at a clock edge is loaded into the first cell
// at that edge and moves on cell by cell to the last one, whose register drives
// the ciphertext output. While the output does not stall, the engine takes a
// new block every cycle; the rate is set by the round pipeline, one cell per
// round.
// A stall on the output side stops only the cells that are full behind it:
// empty slots collapse, so input keeps flowing until every cell holds a block.
module aes128_block_encrypt
    import aesb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // block input transaction
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [HALF_W-1:0]    i_plain_high,
    input  logic [HALF_W-1:0]    i_plain_low,
    // ciphertext output transaction
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [HALF_W-1:0]    o_cipher_high,
    output logic [HALF_W-1:0]    o_cipher_low,
    // key register writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [HALF_W-1:0]    i_cfg_data
);

    logic [HALF_W-1:0] r_key_high, r_key_low;

    // stage 0 is the input port itself; stage k is the register of round cell k
    t_stage                  w_stg [0:NUM_ROUNDS];
    logic [NUM_ROUNDS+1:1]   w_adv;

    // Key registers: always ready, drop writes to unknown indexes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Initial AddRoundKey on the way in; round 1 cell takes the raw key
    assign w_stg[0] = '{
        valid: i_in_valid,
        state: {i_plain_high, i_plain_low} ^ {r_key_high, r_key_low},
        key:   {r_key_high, r_key_low}
    };

    // A cell loads when it is empty or its content moves on this cycle
    assign w_adv[NUM_ROUNDS+1] = !i_out_stall;

    for (genvar k = 1; k <= NUM_ROUNDS; k++) begin : g_round
        assign w_adv[k] = !w_stg[k].valid || w_adv[k+1];

        aesb_cell #(
            .ROUND (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv[k]),
            .i_stage (w_stg[k-1]),
            .o_stage (w_stg[k])
        );
    end

    // Hold input off only when the first cell is full and cannot advance
    assign o_in_stall = !w_adv[1];

    // Last cell register is the output register
    assign o_out_valid   = w_stg[NUM_ROUNDS].valid;
    assign o_cipher_high = w_stg[NUM_ROUNDS].state[BLK_W-1:HALF_W];
    assign o_cipher_low  = w_stg[NUM_ROUNDS].state[HALF_W-1:0];

endmodule

// ===== hw/rtl/aesb_cell.sv =====
module aesb_cell
    import aesb_pkg::*;
#(
    parameter int ROUND = 1
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_adv,
    input  t_stage i_stage,
    output t_stage o_stage
);

    localparam logic [7:0] RC = rcon_of(ROUND);

    logic   r_valid;
    t_block r_state, r_key;
    t_block n_state, n_key, w_sub;

    always_comb begin
        n_key = key_expand(i_stage.key, RC);
        w_sub = sub_shift(i_stage.state);
        // final round skips the column mix
        if (ROUND == NUM_ROUNDS) begin
            n_state = w_sub ^ n_key;
        end else begin
            n_state = col_mix(w_sub) ^ n_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_stage.valid) begin
            r_state <= n_state;
            r_key   <= n_key;
        end
    end

    assign o_stage = '{valid: r_valid, state: r_state, key: r_key};

endmodule
